### rtl/lfr_pkg.sv
package lfr_pkg;

  // pool size and derived widths
  localparam int NUM_FRAMES = 16;
  localparam int FRAME_W    = 4;
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
  localparam int PIN_W      = 8;

  // request action codes
  localparam logic [1:0] ACT_UNPIN  = 2'd0;
  localparam logic [1:0] ACT_PIN    = 2'd1;
  localparam logic [1:0] ACT_VICTIM = 2'd2;

  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

  // operation broadcast to every queue cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] head;
  } cell_ctl_t;

  // queue outcome of one request
  typedef struct packed {
    logic [FRAME_W-1:0] victim_frame;
    logic               victim_valid;
    logic [COUNT_W-1:0] length;
  } q_status_t;

endpackage

### rtl/lfr_cell.sv
module lfr_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfr_pkg::cell_ctl_t         ctl,
  input  logic                       prev_valid,
  input  logic                       hit_in,
  input  logic [lfr_pkg::FRAME_W-1:0] next_id,
  input  logic                       next_valid,
  output logic [lfr_pkg::FRAME_W-1:0] id,
  output logic                       valid,
  output logic                       hit_out
);
  import lfr_pkg::*;

  logic [FRAME_W-1:0] id_r, id_nxt;
  logic               valid_r, valid_nxt;
  logic               match;

  // this cell or one nearer the head holds the frame
  assign match   = valid_r && (id_r == ctl.frame);
  assign hit_out = hit_in | match;

  // next contents from the broadcast operation and the neighbors
  always_comb begin
    id_nxt    = id_r;
    valid_nxt = valid_r;
    case (ctl.op)
      CELL_APPEND: begin
        if (!valid_r && prev_valid) begin
          id_nxt    = ctl.frame;
          valid_nxt = 1'b1;
        end
      end
      CELL_REMOVE: begin
        if (hit_out) begin
          id_nxt    = next_id;
          valid_nxt = next_valid;
        end
      end
      CELL_ROTATE: begin
        if (valid_r) begin
          id_nxt = next_valid ? next_id : ctl.head;
        end
      end
      default: begin
      end
    endcase
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // frame id
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id    = id_r;
  assign valid = valid_r;

endmodule

### rtl/lfr_queue.sv
module lfr_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_en,
  input  logic [1:0]                  action,
  input  logic [lfr_pkg::FRAME_W-1:0] frame,
  input  logic                        in_range,
  output lfr_pkg::q_status_t          status
);
  import lfr_pkg::*;

  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [NUM_FRAMES-1:0] queued_r, queued_nxt;
  logic [FRAME_W-1:0]    ids    [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valids;
  logic [NUM_FRAMES:0]   hits;
  cell_ctl_t             ctl;
  logic                  is_queued;
  logic                  nonempty;

  assign is_queued = queued_r[frame[IDX_W-1:0]];
  assign nonempty  = (count_r != '0);

  // pick the operation and update count and presence map
  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.frame  = frame;
    ctl.head   = ids[0];
    count_nxt  = count_r;
    queued_nxt = queued_r;
    status.victim_frame = '0;
    status.victim_valid = 1'b0;
    if (action == ACT_UNPIN && in_range) begin
      if (!is_queued && count_r < COUNT_W'(NUM_FRAMES)) begin
        ctl.op     = CELL_APPEND;
        count_nxt  = count_r + 1'b1;
        queued_nxt[frame[IDX_W-1:0]] = 1'b1;
      end
    end else if (action == ACT_PIN && in_range) begin
      if (is_queued) begin
        ctl.op     = CELL_REMOVE;
        count_nxt  = count_r - 1'b1;
        queued_nxt[frame[IDX_W-1:0]] = 1'b0;
      end
    end else if (action == ACT_VICTIM) begin
      if (nonempty) begin
        ctl.op              = CELL_ROTATE;
        status.victim_frame = ids[0];
        status.victim_valid = 1'b1;
      end
    end
    if (!req_en) begin
      ctl.op = CELL_HOLD;
    end
    status.length = count_nxt;
  end

  // count and presence map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      queued_r <= '0;
    end else if (req_en) begin
      count_r  <= count_nxt;
      queued_r <= queued_nxt;
    end
  end

  // chain of queue cells, head at cell 0
  assign hits[0] = 1'b0;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    logic               prev_v;
    logic [FRAME_W-1:0] nid;
    logic               nvalid;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = valids[i-1];
    end

    if (i == NUM_FRAMES - 1) begin : g_tail
      assign nid    = '0;
      assign nvalid = 1'b0;
    end else begin : g_inner
      assign nid    = ids[i+1];
      assign nvalid = valids[i+1];
    end

    lfr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_valid (prev_v),
      .hit_in     (hits[i]),
      .next_id    (nid),
      .next_valid (nvalid),
      .id         (ids[i]),
      .valid      (valids[i]),
      .hit_out    (hits[i+1])
    );
  end

  // presence map and count agree
  a_map_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == int'(count_r))
    else $error("presence map disagrees with queue count");

  // number of occupied cells equals the queue count
  a_cells_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valids) == int'(count_r))
    else $error("occupied cells disagree with queue count");

  // rotation keeps the length
  a_rotate_len: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == CELL_ROTATE |=> $stable(count_r))
    else $error("victim rotation changed queue length");

endmodule

### rtl/lru_frame_replacer_top.sv
// LRU frame replacer: pin counts plus a chain of queue cells in replacement order.
// Each accepted request's result is captured in the output register. Throughput:
// one request per cycle while in_stall is low; every queue cell compares, collapses
// and shifts in the same cycle, and a valid result holds while out_stall is high.
// Reset (rst_n low, synchronous): queue empty, presence map and pin counts zero.
module lru_frame_replacer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [lfr_pkg::FRAME_W-1:0] in_frame_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lfr_pkg::FRAME_W-1:0] out_victim_frame,
  output logic                        out_victim_valid,
  output logic [lfr_pkg::COUNT_W-1:0] out_queue_length,
  output logic [lfr_pkg::PIN_W-1:0]   out_pin_level
);
  import lfr_pkg::*;

  logic               accept;
  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [PIN_W-1:0]   pin_counts_r [NUM_FRAMES];
  logic [PIN_W-1:0]   pin_cur, pin_new, level;
  logic               pin_wr;
  q_status_t          q_status;

  logic               out_valid_r;
  logic [FRAME_W-1:0] victim_frame_r;
  logic               victim_valid_r;
  logic [COUNT_W-1:0] queue_length_r;
  logic [PIN_W-1:0]   pin_level_r;

  // request handshake through the output register
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign in_range = (COUNT_W'(in_frame_id) < COUNT_W'(NUM_FRAMES));
  assign idx      = in_frame_id[IDX_W-1:0];

  // saturating pin count update
  always_comb begin
    pin_cur = in_range ? pin_counts_r[idx] : '0;
    pin_new = pin_cur;
    pin_wr  = 1'b0;
    if (in_range && in_action == ACT_UNPIN) begin
      pin_wr = 1'b1;
      if (pin_cur != '0) begin
        pin_new = pin_cur - 1'b1;
      end
    end else if (in_range && in_action == ACT_PIN) begin
      pin_wr = 1'b1;
      if (pin_cur != PIN_MAX) begin
        pin_new = pin_cur + 1'b1;
      end
    end
    level = in_range ? pin_new : '0;
  end

  // pin count storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        pin_counts_r[i] <= '0;
      end
    end else if (accept && pin_wr) begin
      pin_counts_r[idx] <= pin_new;
    end
  end

  // replacement order queue
  lfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_en   (accept),
    .action   (in_action),
    .frame    (in_frame_id),
    .in_range (in_range),
    .status   (q_status)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      victim_frame_r <= q_status.victim_frame;
      victim_valid_r <= q_status.victim_valid;
      queue_length_r <= q_status.length;
      pin_level_r    <= level;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_victim_frame = victim_frame_r;
  assign out_victim_valid = victim_valid_r;
  assign out_queue_length = queue_length_r;
  assign out_pin_level    = pin_level_r;

  // an accepted request always leaves a result behind
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  // a result without a victim carries frame zero
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !victim_valid_r |-> victim_frame_r == '0)
    else $error("victim frame set without a valid victim");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(queue_length_r)
      && $stable(pin_level_r) && $stable(victim_frame_r) && $stable(victim_valid_r))
    else $error("stalled result changed");

endmodule
